@@ src/dawm_pkg.sv @@
package dawm_pkg;

    localparam int POS_W = 11;
    localparam int DIM_W = 12;
    localparam int LEVEL_W = 8;
    localparam int LEVELS = 256;
    localparam int SEARCH_STEPS = 8;
    localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;
    localparam logic [DIM_W-1:0] DIM_RESET = 12'd2048;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PI_Q52 = 64'h0032_43F6_A888_5A31;

    typedef enum logic [1:0] {
        REG_LEAN,
        REG_TRANSPOSE,
        REG_WIDTH,
        REG_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic             lean;
        logic             transpose;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   x_pos;
        logic [POS_W-1:0]   y_pos;
        logic               nonzero;
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   first_major;
        logic [POS_W-1:0]   first_minor;
        logic [POS_W-1:0]   second_major;
        logic [POS_W-1:0]   second_minor;
    } stage_t;

    typedef logic [31:0] tan_tab_t [LEVELS];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [31:0] tan_entry(input int unsigned k, input int unsigned frac);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] sterm;
        logic [63:0] ssum;
        logic [63:0] cterm;
        logic [63:0] csum;
        logic [63:0] q;
        logic [63:0] r;
        th = 64'(k) * PI_Q52;
        th2 = mul_q62(th, th);
        sterm = th;
        ssum = th;
        cterm = Q62_ONE;
        csum = Q62_ONE;
        q = 64'd0;
        for (int i = 1; i <= 12; i++)
        begin
            sterm = mul_q62(sterm, th2) / 64'((2 * i) * (2 * i + 1));
            cterm = mul_q62(cterm, th2) / 64'((2 * i - 1) * (2 * i));
            if ((i & 1) != 0)
            begin
                ssum = ssum - sterm;
                csum = csum - cterm;
            end
            else
            begin
                ssum = ssum + sterm;
                csum = csum + cterm;
            end
        end
        r = ssum;
        for (int unsigned i = 0; i < frac; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= csum)
            begin
                r = r - csum;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= csum)
        begin
            q = q + 64'd1;
        end
        return q[31:0];
    endfunction

    function automatic tan_tab_t tan_table(input int unsigned frac);
        tan_tab_t t;
        t[0] = 32'd0;
        for (int k = 1; k < LEVELS; k++)
        begin
            t[k] = tan_entry(k, frac);
        end
        return t;
    endfunction

endpackage

@@ src/dawm_coord_if.sv @@
interface dawm_coord_if;
    logic                       valid;
    logic                       ready;
    logic [dawm_pkg::POS_W-1:0] x_pos;
    logic [dawm_pkg::POS_W-1:0] y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

@@ src/dawm_mask_if.sv @@
interface dawm_mask_if;
    logic                         valid;
    logic                         ready;
    logic [dawm_pkg::LEVEL_W-1:0] level;
    logic [dawm_pkg::POS_W-1:0]   first_major;
    logic [dawm_pkg::POS_W-1:0]   first_minor;
    logic [dawm_pkg::POS_W-1:0]   second_major;
    logic [dawm_pkg::POS_W-1:0]   second_minor;

    modport source (output valid, output level, output first_major, output first_minor,
                    output second_major, output second_minor, input ready);
    modport sink (input valid, input level, input first_major, input first_minor,
                  input second_major, input second_minor, output ready);
endinterface

@@ src/dawm_front.sv @@
module dawm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [dawm_pkg::POS_W-1:0] x_pos,
    input  logic [dawm_pkg::POS_W-1:0] y_pos,
    input  dawm_pkg::cfg_t             cfg,
    output logic                       valid,
    output dawm_pkg::stage_t           stage
);
    import dawm_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    stage_t           stage_reg;
    stage_t           stage_next;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] x_ext;
    logic [DIM_W-1:0] y_ext;
    logic [DIM_W-1:0] c1;
    logic [DIM_W-1:0] c2;
    logic [DIM_W-1:0] r2;
    logic             keep;

    always_comb
    begin
        w = (cfg.width > MAX_DIM) ? MAX_DIM : cfg.width;
        h = (cfg.height > MAX_DIM) ? MAX_DIM : cfg.height;
        x_ext = DIM_W'(x_pos);
        y_ext = DIM_W'(y_pos);
        keep = (y_pos <= x_pos) && (x_ext < w) && (y_ext < h);
        c1 = cfg.lean ? (w - 12'd1 - x_ext) : x_ext;
        c2 = w - 12'd1 - c1;
        r2 = h - 12'd1 - y_ext;
        valid_next = in_valid && keep;
        stage_next.x_pos = x_pos;
        stage_next.y_pos = y_pos;
        stage_next.nonzero = (x_pos != '0);
        stage_next.level = '0;
        if (cfg.transpose)
        begin
            stage_next.first_major = c1[POS_W-1:0];
            stage_next.first_minor = y_pos;
            stage_next.second_major = c2[POS_W-1:0];
            stage_next.second_minor = r2[POS_W-1:0];
        end
        else
        begin
            stage_next.first_major = y_pos;
            stage_next.first_minor = c1[POS_W-1:0];
            stage_next.second_major = r2[POS_W-1:0];
            stage_next.second_minor = c2[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;
endmodule

@@ src/dawm_step.sv @@
module dawm_step #(
    parameter int FRAC_BITS = 20,
    parameter int STEP_BIT = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  dawm_pkg::stage_t in_stage,
    output logic             valid,
    output dawm_pkg::stage_t stage
);
    import dawm_pkg::*;

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = POS_W + FRAC_BITS + 1;
    localparam tan_tab_t TAB = tan_table(FRAC_BITS);
    localparam logic [LEVEL_W-1:0] PROBE = LEVEL_W'(1) << STEP_BIT;

    logic               valid_reg;
    stage_t             stage_reg;
    stage_t             stage_next;
    logic [LEVEL_W-1:0] cand;
    logic [TW-1:0]      tan_val;
    logic [PW-1:0]      lhs;
    logic [PW-1:0]      prod;

    always_comb
    begin
        cand = in_stage.level | PROBE;
        tan_val = TAB[cand][TW-1:0];
        lhs = PW'({in_stage.y_pos, {FRAC_BITS{1'b0}}});
        prod = PW'(in_stage.x_pos) * PW'(tan_val);
        stage_next = in_stage;
        if (in_stage.nonzero && (lhs >= prod))
        begin
            stage_next.level = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;
endmodule

@@ src/diagonal_angle_wipe_mask.sv @@
// Channel   Role    Word
// coord     sink    x_pos, y_pos
// mask      source  level, first_major, first_minor, second_major, second_minor
// apb       slave   lean, transpose, width, height at byte 0, 4, 8, 12
//
// One coordinate accepted per clock unless the mask output stalls.
// The level comes from an 8-step binary search of the tangent table, one
// multiply-and-compare stage per bit, behind a qualifying/position stage.
// Reset clears all stage valid bits and restores register defaults.
// Each stage advances when empty or when the next one advances; bubbles close
// up under output stall, and coordinates outside the octant or frame are dropped.
module diagonal_angle_wipe_mask #(
    parameter int TAN_FRAC_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dawm_coord_if.sink                  coord,
    dawm_mask_if.source                 mask,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dawm_pkg::ADDR_W-1:0] paddr,
    input  logic [dawm_pkg::DATA_W-1:0] pwdata,
    output logic [dawm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import dawm_pkg::*;

    localparam int LAST = SEARCH_STEPS;

    cfg_t              cfg_reg;
    reg_idx_t          idx;
    logic              wr;
    logic [LAST:0]     vld;
    logic [LAST:0]     en;
    stage_t            st [LAST+1];

    assign pready = 1'b1;
    assign idx = reg_idx_t'(paddr[3:2]);
    assign wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lean <= 1'b0;
            cfg_reg.transpose <= 1'b0;
            cfg_reg.width <= DIM_RESET;
            cfg_reg.height <= DIM_RESET;
        end
        else if (wr)
        begin
            case (idx)
                REG_LEAN:      cfg_reg.lean <= pwdata[0];
                REG_TRANSPOSE: cfg_reg.transpose <= pwdata[0];
                REG_WIDTH:     cfg_reg.width <= pwdata[DIM_W-1:0];
                REG_HEIGHT:    cfg_reg.height <= pwdata[DIM_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LEAN:      prdata = DATA_W'(cfg_reg.lean);
            REG_TRANSPOSE: prdata = DATA_W'(cfg_reg.transpose);
            REG_WIDTH:     prdata = DATA_W'(cfg_reg.width);
            REG_HEIGHT:    prdata = DATA_W'(cfg_reg.height);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        en[LAST] = !vld[LAST] || mask.ready;
        for (int j = LAST - 1; j >= 0; j--)
        begin
            en[j] = !vld[j] || en[j+1];
        end
    end

    assign coord.ready = en[0];

    dawm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[0]),
        .in_valid (coord.valid),
        .x_pos    (coord.x_pos),
        .y_pos    (coord.y_pos),
        .cfg      (cfg_reg),
        .valid    (vld[0]),
        .stage    (st[0])
    );

    for (genvar j = 1; j <= LAST; j++)
    begin : g_step
        dawm_step #(
            .FRAC_BITS (TAN_FRAC_BITS),
            .STEP_BIT  (LAST - j)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en[j]),
            .in_valid (vld[j-1]),
            .in_stage (st[j-1]),
            .valid    (vld[j]),
            .stage    (st[j])
        );
    end

    assign mask.valid = vld[LAST];
    assign mask.level = st[LAST].level;
    assign mask.first_major = st[LAST].first_major;
    assign mask.first_minor = st[LAST].first_minor;
    assign mask.second_major = st[LAST].second_major;
    assign mask.second_minor = st[LAST].second_minor;

    a_octant: assert property (@(posedge clk) disable iff (!rst_n)
        vld[LAST] |-> (st[LAST].y_pos <= st[LAST].x_pos))
        else $error("result outside octant");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (vld[LAST] && !st[LAST].nonzero) |-> (st[LAST].level == '0))
        else $error("origin level not zero");

    a_diagonal: assert property (@(posedge clk) disable iff (!rst_n)
        (vld[LAST] && st[LAST].nonzero && (st[LAST].x_pos == st[LAST].y_pos))
        |-> (st[LAST].level == '1))
        else $error("diagonal level not full");

    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!vld[0] && coord.valid && coord.ready) |=> (vld[0] || ($past(vld[1]) == vld[1])
        || $past(en[1])))
        else $error("front stage lost word");
endmodule

@@ bench/diagonal_angle_wipe_mask_test.sv @@
module diagonal_angle_wipe_mask_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dawm_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int FRAC = 20;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   first_major;
        logic [POS_W-1:0]   first_minor;
        logic [POS_W-1:0]   second_major;
        logic [POS_W-1:0]   second_minor;
    } mask_word_t;

    class wipe_mask_board;
        bit [63:0]        tan_q [LEVELS];
        bit               lean_r;
        bit               transpose_r;
        bit [DIM_W-1:0]   width_r;
        bit [DIM_W-1:0]   height_r;
        mask_word_t       due_masks [$];
        int unsigned      errors;
        int unsigned      coords_seen;
        int unsigned      masks_seen;

        function bit [63:0] q62_product(bit [63:0] a, bit [63:0] b);
            bit [127:0] p;
            p = 128'(a) * 128'(b);
            return p[125:62];
        endfunction

        function new();
            bit [63:0] th;
            bit [63:0] th2;
            bit [63:0] s_term;
            bit [63:0] s_sum;
            bit [63:0] c_term;
            bit [63:0] c_sum;
            bit [63:0] quo;
            bit [63:0] rem;
            lean_r = 1'b0;
            transpose_r = 1'b0;
            width_r = DIM_RESET;
            height_r = DIM_RESET;
            errors = 0;
            coords_seen = 0;
            masks_seen = 0;
            tan_q[0] = 64'd0;
            for (int k = 1; k < LEVELS; k++)
            begin
                th = 64'(k) * PI_Q52;
                th2 = q62_product(th, th);
                s_term = th;
                s_sum = th;
                c_term = Q62_ONE;
                c_sum = Q62_ONE;
                for (int n = 1; n <= 12; n++)
                begin
                    s_term = q62_product(s_term, th2) / 64'((2 * n) * (2 * n + 1));
                    c_term = q62_product(c_term, th2) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                    begin
                        s_sum -= s_term;
                        c_sum -= c_term;
                    end
                    else
                    begin
                        s_sum += s_term;
                        c_sum += c_term;
                    end
                end
                rem = s_sum;
                quo = 64'd0;
                for (int n = 0; n < FRAC; n++)
                begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= c_sum)
                    begin
                        rem -= c_sum;
                        quo[0] = 1'b1;
                    end
                end
                if ((rem << 1) >= c_sum)
                    quo += 64'd1;
                tan_q[k] = quo;
            end
        endfunction

        function bit [DIM_W-1:0] clamp_dim(bit [DIM_W-1:0] v);
            return (v > MAX_DIM) ? MAX_DIM : v;
        endfunction

        function void set_reg(reg_idx_t idx, bit [31:0] value);
            case (idx)
                REG_LEAN:      lean_r = value[0];
                REG_TRANSPOSE: transpose_r = value[0];
                REG_WIDTH:     width_r = value[DIM_W-1:0];
                REG_HEIGHT:    height_r = value[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [LEVEL_W-1:0] wipe_level(bit [POS_W-1:0] x, bit [POS_W-1:0] y);
            bit [63:0] lhs;
            int unsigned count;
            count = 0;
            if (x != 0)
            begin
                lhs = 64'(y) << FRAC;
                for (int k = 1; k < LEVELS; k++)
                    if (lhs >= 64'(x) * tan_q[k])
                        count++;
            end
            return count[LEVEL_W-1:0];
        endfunction

        function void note_coord(bit [POS_W-1:0] x, bit [POS_W-1:0] y);
            bit [DIM_W-1:0] w;
            bit [DIM_W-1:0] h;
            bit [DIM_W-1:0] c1;
            bit [DIM_W-1:0] c2;
            bit [DIM_W-1:0] r2;
            mask_word_t m;
            coords_seen++;
            w = clamp_dim(width_r);
            h = clamp_dim(height_r);
            if (y > x || DIM_W'(x) >= w || DIM_W'(y) >= h)
                return;
            c1 = lean_r ? (w - 12'd1 - DIM_W'(x)) : DIM_W'(x);
            c2 = w - 12'd1 - c1;
            r2 = h - 12'd1 - DIM_W'(y);
            m.level = wipe_level(x, y);
            if (transpose_r)
            begin
                m.first_major = c1[POS_W-1:0];
                m.first_minor = y;
                m.second_major = c2[POS_W-1:0];
                m.second_minor = r2[POS_W-1:0];
            end
            else
            begin
                m.first_major = y;
                m.first_minor = c1[POS_W-1:0];
                m.second_major = r2[POS_W-1:0];
                m.second_minor = c2[POS_W-1:0];
            end
            due_masks.push_back(m);
        endfunction

        function void check_mask(mask_word_t got);
            mask_word_t want;
            masks_seen++;
            if (due_masks.size() == 0)
            begin
                $error("unexpected mask word: level %0d first %0d/%0d second %0d/%0d",
                       got.level, got.first_major, got.first_minor,
                       got.second_major, got.second_minor);
                errors++;
                return;
            end
            want = due_masks.pop_front();
            if (got.level !== want.level)
            begin
                $error("level: expected %0d, got %0d", want.level, got.level);
                errors++;
            end
            if (got.first_major !== want.first_major)
            begin
                $error("first_major: expected %0d, got %0d", want.first_major, got.first_major);
                errors++;
            end
            if (got.first_minor !== want.first_minor)
            begin
                $error("first_minor: expected %0d, got %0d", want.first_minor, got.first_minor);
                errors++;
            end
            if (got.second_major !== want.second_major)
            begin
                $error("second_major: expected %0d, got %0d",
                       want.second_major, got.second_major);
                errors++;
            end
            if (got.second_minor !== want.second_minor)
            begin
                $error("second_minor: expected %0d, got %0d",
                       want.second_minor, got.second_minor);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dawm_coord_if coord_bus ();
    dawm_mask_if  mask_bus ();

    diagonal_angle_wipe_mask u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .coord   (coord_bus),
        .mask    (mask_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wipe_mask_board board = new();
    bit             calm = 1'b0;
    int unsigned    settings_run = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && coord_bus.valid && coord_bus.ready)
            board.note_coord(coord_bus.x_pos, coord_bus.y_pos);
        if (rst_n && mask_bus.valid && mask_bus.ready)
            board.check_mask({mask_bus.level, mask_bus.first_major, mask_bus.first_minor,
                              mask_bus.second_major, mask_bus.second_minor});
    end

    // stall the result side in bursts; hold ready high once calm
    initial
    begin
        forever
        begin
            mask_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm)
            begin
                mask_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    task automatic send_coord(input bit [POS_W-1:0] x, input bit [POS_W-1:0] y);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            coord_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        coord_bus.valid <= 1'b1;
        coord_bus.x_pos <= x;
        coord_bus.y_pos <= y;
        do
            @(posedge clk);
        while (!coord_bus.ready);
    endtask

    task automatic apb_write(input reg_idx_t idx, input bit [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic settle();
        coord_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.due_masks.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input bit lean, input bit transpose,
                                 input bit [DIM_W-1:0] w, input bit [DIM_W-1:0] h);
        settle();
        apb_write(REG_LEAN, 32'(lean));
        apb_write(REG_TRANSPOSE, 32'(transpose));
        apb_write(REG_WIDTH, 32'(w));
        apb_write(REG_HEIGHT, 32'(h));
        settings_run++;
    endtask

    // mostly in-frame octant words, some edge hits, the rest noise or near misses
    task automatic run_random(input int unsigned count);
        bit [DIM_W-1:0] w;
        bit [DIM_W-1:0] h;
        bit [POS_W-1:0] x;
        bit [POS_W-1:0] y;
        int unsigned    ymax;
        int unsigned    pick;
        w = board.clamp_dim(board.width_r);
        h = board.clamp_dim(board.height_r);
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            x = POS_W'($urandom);
            y = POS_W'($urandom);
            if (pick < 75 && w != 0 && h != 0)
            begin
                x = POS_W'($urandom_range(0, w - 1));
                ymax = (x < h - 1) ? x : h - 1;
                y = POS_W'($urandom_range(0, ymax));
            end
            else if (pick < 85 && w != 0 && h != 0)
            begin
                x = ($urandom_range(0, 1) == 1) ? POS_W'(w - 1) : POS_W'($urandom_range(0, w - 1));
                ymax = (x < h - 1) ? x : h - 1;
                y = ($urandom_range(0, 1) == 1) ? POS_W'(ymax) : '0;
            end
            else if (pick < 92)
            begin
                if (x != {POS_W{1'b1}})
                    y = x + POS_W'(1);
                else if (w <= 12'd2047)
                    x = POS_W'(w);
            end
            send_coord(x, y);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        coord_bus.valid <= 1'b0;
        coord_bus.x_pos <= '0;
        coord_bus.y_pos <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(2047, 0);
        send_coord(2047, 1);
        send_coord(2047, 2046);
        send_coord(1, 1);
        send_coord(1, 0);
        send_coord(2, 1);
        send_coord(1, 2);
        send_coord(0, 5);
        send_coord(1, 2047);
        send_coord(1024, 1023);
        send_coord(1365, 1);
        send_coord(100, 41);
        send_coord(2046, 1000);

        apply_setting(1'b1, 1'b1, 12'd2048, 12'd2048);
        send_coord(0, 0);
        send_coord(2047, 2047);
        send_coord(2047, 0);
        send_coord(5, 3);

        apply_setting(1'b0, 1'b0, 12'd0, 12'd5);
        send_coord(0, 0);

        apply_setting(1'b1, 1'b0, 12'd1, 12'd1);
        send_coord(0, 0);
        send_coord(1, 0);

        apply_setting(1'b0, 1'b1, 12'hFFF, 12'hFFF);
        send_coord(2047, 2047);

        apply_setting(1'b0, 1'b0, 12'd2048, 12'd2048);
        run_random(300);
        apply_setting(1'b1, 1'b1, 12'd2048, 12'd2048);
        run_random(300);
        apply_setting(1'b1, 1'b0, 12'd640, 12'd480);
        run_random(250);
        apply_setting(1'b0, 1'b1, 12'd1, 12'd2048);
        run_random(60);
        apply_setting(1'b0, 1'b0, 12'd0, 12'd0);
        run_random(30);
        apply_setting(1'b1, 1'b1, 12'hFFF, 12'd2049);
        run_random(250);
        apply_setting(1'b0, 1'b0, 12'd17, 12'd3);
        run_random(150);
        repeat (2)
        begin
            apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          DIM_W'($urandom_range(1, 2048)), DIM_W'($urandom_range(1, 2048)));
            run_random(150);
        end

        apply_setting(1'b1, 1'b0, 12'd2048, 12'd1);
        calm = 1'b1;
        run_random(200);
        settle();

        $display("checked %0d mask words from %0d coordinates over %0d register settings",
                 board.masks_seen, board.coords_seen, settings_run + 1);
        $display("settings spanned lean and transpose both ways, zero, unit, odd and oversized frames");
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
